// ----- hdl/binary_row_run_length_encoder_defines.svh -----
// Assertion macros for the run-length encoder top level.
`ifndef BINARY_ROW_RUN_LENGTH_ENCODER_DEFINES_SVH
`define BINARY_ROW_RUN_LENGTH_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BRLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("run-length encoder check failed");

// Next-cycle implication, checked outside reset.
`define BRLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("run-length encoder check failed");

`endif

// ----- hdl/brle_pkg.sv -----
// Shared constants and controller/datapath interface types for the run-length encoder.
package brle_pkg;

  localparam int MAX_COLS  = 64;
  localparam int COL_W     = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int RUN_DEPTH = 32;
  localparam int RUN_AW    = $clog2(RUN_DEPTH);
  localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
  localparam int OUT_W     = 6;

  localparam logic [1:0] KIND_WHITE = 2'd0;
  localparam logic [1:0] KIND_EOW   = 2'd1;
  localparam logic [1:0] KIND_BLACK = 2'd2;
  localparam logic [1:0] KIND_EOR   = 2'd3;

  typedef struct packed {
    logic accept;
    logic load_eow;
    logic rd_en;
    logic load_black;
    logic load_eor;
  } brle_cmd_t;

  typedef struct packed {
    logic end_pix;
    logic runs_done;
    logic out_free;
  } brle_sts_t;

endpackage

// ----- hdl/brle_ctrl.sv -----
// Controller: accepts pixel requests and sequences the row-end burst.
module brle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  brle_pkg::brle_sts_t sts,
  output brle_pkg::brle_cmd_t cmd
);
  import brle_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EOW   = 5'b00010,
    S_FETCH = 5'b00100,
    S_BLACK = 5'b01000,
    S_EOR   = 5'b10000
  } brle_state_t;

  brle_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
        if (cmd.accept && sts.end_pix) begin
          state_nxt = S_EOW;
        end
      end
      S_EOW: begin
        if (sts.out_free) begin
          cmd.load_eow = 1'b1;
          state_nxt    = S_FETCH;
        end
      end
      S_FETCH: begin
        if (sts.runs_done) begin
          state_nxt = S_EOR;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_BLACK;
        end
      end
      S_BLACK: begin
        if (sts.out_free) begin
          cmd.load_black = 1'b1;
          state_nxt      = S_FETCH;
        end
      end
      S_EOR: begin
        if (sts.out_free) begin
          cmd.load_eor = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/brle_datapath.sv -----
// Datapath: run tracking, black run store and the output register.
module brle_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_pixel,
  input  logic               in_row_end,
  input  brle_pkg::brle_cmd_t cmd,
  output brle_pkg::brle_sts_t sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [5:0]         out_run_start,
  output logic [5:0]         out_run_end,
  output logic               out_last
);
  import brle_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RUN_DEPTH);

  function automatic logic [OUT_W-1:0] col_out(input logic [COL_W-1:0] c);
    logic [COL_W+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, c};
    return w[OUT_W-1:0];
  endfunction

  logic [COL_W-1:0] col_r, col_nxt;
  logic             white_open_r, white_open_nxt;
  logic [COL_W-1:0] white_first_r, white_first_nxt;
  logic             black_open_r, black_open_nxt;
  logic [COL_W-1:0] black_first_r, black_first_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic [11:0]      rd_data_r;
  logic [11:0]      black_runs [RUN_DEPTH];
  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [OUT_W-1:0] out_start_r;
  logic [OUT_W-1:0] out_end_r;
  logic             out_last_r;

  logic             pix_white;
  logic             end_pix;
  logic             emit;
  logic [COL_W-1:0] emit_s, emit_e;
  logic             store;
  logic [COL_W-1:0] store_s, store_e;
  logic             wr_en;
  logic             out_free;

  assign pix_white = (in_pixel != 8'd0);
  assign end_pix   = in_row_end || (col_r == LAST_COL);
  assign out_free  = !out_valid_r || out_ready;
  assign wr_en     = cmd.accept && store && (count_r < FULL_CNT);

  assign sts.end_pix   = end_pix;
  assign sts.runs_done = (rd_idx_r == count_r);
  assign sts.out_free  = out_free;

  // Next run state for the pixel on the input, plus at most one emit and one store.
  always_comb begin
    white_open_nxt  = white_open_r;
    white_first_nxt = white_first_r;
    black_open_nxt  = black_open_r;
    black_first_nxt = black_first_r;
    emit    = 1'b0;
    emit_s  = white_first_r;
    emit_e  = col_r;
    store   = 1'b0;
    store_s = black_first_r;
    store_e = col_r;
    if (pix_white) begin
      if (!white_open_nxt) begin
        white_first_nxt = col_r;
        white_open_nxt  = 1'b1;
      end
      if (black_open_nxt) begin
        store          = 1'b1;
        store_s        = black_first_nxt;
        store_e        = col_r - 1'b1;
        black_open_nxt = 1'b0;
      end
    end else begin
      if (white_open_nxt) begin
        emit           = 1'b1;
        emit_s         = white_first_nxt;
        emit_e         = col_r - 1'b1;
        white_open_nxt = 1'b0;
      end
      if (!black_open_nxt) begin
        black_first_nxt = col_r;
        black_open_nxt  = 1'b1;
      end
    end
    if (end_pix) begin
      // close whatever is still open at this column
      if (white_open_nxt) begin
        emit   = 1'b1;
        emit_s = white_first_nxt;
        emit_e = col_r;
      end
      if (black_open_nxt) begin
        store   = 1'b1;
        store_s = black_first_nxt;
        store_e = col_r;
      end
      white_open_nxt = 1'b0;
      black_open_nxt = 1'b0;
      col_nxt        = '0;
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      white_open_r  <= 1'b0;
      white_first_r <= '0;
      black_open_r  <= 1'b0;
      black_first_r <= '0;
      count_r       <= '0;
      rd_idx_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        col_r         <= col_nxt;
        white_open_r  <= white_open_nxt;
        white_first_r <= white_first_nxt;
        black_open_r  <= black_open_nxt;
        black_first_r <= black_first_nxt;
      end
      if (wr_en) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.load_eor) begin
        count_r <= '0;
      end
      if (cmd.rd_en) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end else if (cmd.load_eor) begin
        rd_idx_r <= '0;
      end
      if ((cmd.accept && emit) || cmd.load_eow || cmd.load_black || cmd.load_eor) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Run store: one write port, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      black_runs[count_r[RUN_AW-1:0]] <= {col_out(store_s), col_out(store_e)};
    end
    if (cmd.rd_en) begin
      rd_data_r <= black_runs[rd_idx_r[RUN_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && emit) begin
      out_kind_r  <= KIND_WHITE;
      out_start_r <= col_out(emit_s);
      out_end_r   <= col_out(emit_e);
      out_last_r  <= !end_pix;
    end else if (cmd.load_eow) begin
      out_kind_r  <= KIND_EOW;
      out_start_r <= '0;
      out_end_r   <= '0;
      out_last_r  <= 1'b0;
    end else if (cmd.load_black) begin
      out_kind_r  <= KIND_BLACK;
      out_start_r <= rd_data_r[11:6];
      out_end_r   <= rd_data_r[5:0];
      out_last_r  <= 1'b0;
    end else if (cmd.load_eor) begin
      out_kind_r  <= KIND_EOR;
      out_start_r <= '0;
      out_end_r   <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_run_start = out_start_r;
  assign out_run_end   = out_end_r;
  assign out_last      = out_last_r;

endmodule

// ----- hdl/binary_row_run_length_encoder.sv -----
// Top level of the binary row run-length encoder. Pixels of a row are taken one
// per cycle while the output register is free; a white run that closes mid-row is
// loaded straight into the output register as the pixel is accepted. A pixel that
// ends the row (row_end set, or column MAX_COLS-1) starts a burst during which no
// pixel is taken: the end-of-white marker, then each stored black run, then the
// end-of-row marker. Each stored black run is first read from the run store's
// registered port and then loaded into the output register, as sequenced by the
// controller.
`include "binary_row_run_length_encoder_defines.svh"

module binary_row_run_length_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel,
  input  logic       in_row_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [5:0] out_run_start,
  output logic [5:0] out_run_end,
  output logic       out_last
);
  import brle_pkg::*;

  brle_cmd_t cmd;
  brle_sts_t sts;

  brle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  brle_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_pixel      (in_pixel),
    .in_row_end    (in_row_end),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_run_start (out_run_start),
    .out_run_end   (out_run_end),
    .out_last      (out_last)
  );

  // a row-end pixel must hold off the next request for the burst
  `BRLE_ASSERT_NXT(a_end_blocks, clk, rst_n, cmd.accept && sts.end_pix, !in_ready)
  // black runs only leave while the burst holds the input
  `BRLE_ASSERT_IMP(a_black_in_burst, clk, rst_n, out_valid && out_kind == KIND_BLACK, !in_ready)
  // the end-of-row marker always closes its request
  `BRLE_ASSERT_IMP(a_eor_last, clk, rst_n, out_valid && out_kind == KIND_EOR, out_last)
  // a store read never runs past the stored runs
  `BRLE_ASSERT_IMP(a_rd_bound, clk, rst_n, cmd.rd_en, !sts.runs_done)

endmodule
